### rtl/core/scaled_glyph_text_pixel_assert.svh
// Assertion macros used by the text pixel queue.
`ifndef SCALED_GLYPH_TEXT_PIXEL_ASSERT_SVH
`define SCALED_GLYPH_TEXT_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SGTP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SGTP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sgtp_pkg.sv
// Shared types, constants and the 5x7 font ROM for the text pixel block.
`default_nettype none

package sgtp_pkg;

  localparam int CODE_W      = 8;
  localparam int XY_W        = 6;
  localparam int PIX_W       = 32;
  localparam int SCALE_REG_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int MAX_SCALE   = 8;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;

  localparam int SCALE_W   = $clog2(MAX_SCALE + 1);
  localparam int THR_W     = $clog2(GLYPH_ROWS * MAX_SCALE + 1);
  localparam int CMP_W     = (THR_W > XY_W) ? THR_W : XY_W;
  localparam int COL_IDX_W = $clog2(GLYPH_COLS + 1);
  localparam int ROW_IDX_W = $clog2(GLYPH_ROWS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_COLOR = 2'd2;

  localparam logic [SCALE_REG_W-1:0] SCALE_RESET  = 4'd1;
  localparam logic [PIX_W-1:0]       INK_RESET    = 32'hFFE5_F4F7;
  localparam logic [PIX_W-1:0]       SHADOW_RESET = 32'hFF0A_0806;

  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [1:0] {
    COVER_BG     = 2'd0,
    COVER_SHADOW = 2'd1,
    COVER_INK    = 2'd2
  } cover_t;

  // row 0 is the top row; bit GLYPH_COLS-1 of a row is the leftmost dot
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  typedef struct packed {
    glyph_t                 glyph;
    logic [COL_IDX_W-1:0]   ink_col;
    logic [ROW_IDX_W-1:0]   ink_row;
    logic [COL_IDX_W-1:0]   sh_col;
    logic [ROW_IDX_W-1:0]   sh_row;
    logic                   sh_ok;
    logic [PIX_W-1:0]       bg;
  } sgtp_item_t;

  // code is already folded to upper case
  function automatic glyph_t font_lookup(input logic [CODE_W-1:0] code);
    glyph_t g;
    unique case (code)
      8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
      8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: g = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}; // space
      8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
      8'h2F: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}; // slash
      8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // bang
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04}; // period
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00}; // dash
      default: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}; // '?'
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/core/scaled_glyph_text_pixel.sv
// Top level of the scaled 5x7 text overlay pixel generator.
// Usage:
//   Input side is a queue: drive char_code, cell_x, cell_y, background_pixel
//   with push high; the item is taken at an edge where full is low.
//   Result side is a queue: while empty is low, pixel_color and coverage show
//   the oldest result; it is taken at an edge where pop is high.
//   Registers are written through cfg_we / cfg_index / cfg_data, index 0 is
//   glyph_scale, 1 ink_color, 2 shadow_color; other indexes are dropped.
// Timing:
//   One item per cycle sustained while pop drains the results. A result
//   passes through the front register, then the queue, then the result
//   register before it shows on the output. The rate is set by the front
//   lookup/compare stage and the result register, each taking one item
//   per clock while not stalled.
// Stall:
//   When pop stays low the result register holds, the four-entry queue fills,
//   then the front stage holds and full rises; nothing is dropped.
// Reset:
//   rst (synchronous) empties all stages and loads scale 1 and the default
//   ink and shadow colors.
`default_nettype none

module scaled_glyph_text_pixel (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [sgtp_pkg::CODE_W-1:0]     char_code,
  input  logic [sgtp_pkg::XY_W-1:0]       cell_x,
  input  logic [sgtp_pkg::XY_W-1:0]       cell_y,
  input  logic [sgtp_pkg::PIX_W-1:0]      background_pixel,
  output logic                            empty,
  input  logic                            pop,
  output logic [sgtp_pkg::PIX_W-1:0]      pixel_color,
  output logic [1:0]                      coverage,
  input  logic                            cfg_we,
  input  logic [sgtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sgtp_pkg::*;

  // configuration registers
  logic [SCALE_REG_W-1:0] glyph_scale;
  logic [PIX_W-1:0]       ink_color;
  logic [PIX_W-1:0]       shadow_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale  <= SCALE_RESET;
      ink_color    <= INK_RESET;
      shadow_color <= SHADOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_SCALE:  glyph_scale  <= cfg_data[SCALE_REG_W-1:0];
        REG_INK_COLOR:    ink_color    <= cfg_data[PIX_W-1:0];
        REG_SHADOW_COLOR: shadow_color <= cfg_data[PIX_W-1:0];
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // front -> queue
  logic       fr_in_ready;
  logic       fr_valid;
  logic       q_wr_ready;
  sgtp_item_t fr_item;

  // queue -> back
  logic       q_rd_valid;
  logic       bk_in_ready;
  sgtp_item_t q_item;

  logic       bk_valid;

  sgtp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (push),
    .in_ready         (fr_in_ready),
    .char_code        (char_code),
    .cell_x           (cell_x),
    .cell_y           (cell_y),
    .background_pixel (background_pixel),
    .glyph_scale      (glyph_scale),
    .out_valid        (fr_valid),
    .out_ready        (q_wr_ready),
    .out_item         (fr_item)
  );

  sgtp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (bk_in_ready),
    .rd_item  (q_item)
  );

  sgtp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_rd_valid),
    .in_ready     (bk_in_ready),
    .in_item      (q_item),
    .ink_color    (ink_color),
    .shadow_color (shadow_color),
    .out_valid    (bk_valid),
    .out_ready    (pop),
    .pixel_color  (pixel_color),
    .coverage     (coverage)
  );

  assign full  = !fr_in_ready;
  assign empty = !bk_valid;

endmodule

`default_nettype wire

### rtl/core/sgtp_front.sv
// Front stage: case fold, font lookup and dot cell indexing for one pixel.
`default_nettype none

module sgtp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sgtp_pkg::CODE_W-1:0]      char_code,
  input  logic [sgtp_pkg::XY_W-1:0]        cell_x,
  input  logic [sgtp_pkg::XY_W-1:0]        cell_y,
  input  logic [sgtp_pkg::PIX_W-1:0]       background_pixel,
  input  logic [sgtp_pkg::SCALE_REG_W-1:0] glyph_scale,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sgtp_pkg::sgtp_item_t             out_item
);
  import sgtp_pkg::*;

  logic                 valid;
  sgtp_item_t           item;
  sgtp_item_t           item_next;
  logic [CODE_W-1:0]    code_f;
  logic [SCALE_W-1:0]   scale_eff;
  logic [CMP_W-1:0]     px;
  logic [CMP_W-1:0]     py;
  logic [CMP_W-1:0]     thr [1:GLYPH_ROWS];

  always_comb begin
    if (glyph_scale == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (32'(glyph_scale) > MAX_SCALE) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end else begin
      scale_eff = SCALE_W'(glyph_scale);
    end
  end

  // k * scale boundaries; multiplier is a small constant per k
  always_comb begin
    for (int k = 1; k <= GLYPH_ROWS; k++) begin
      thr[k] = CMP_W'(k) * CMP_W'(scale_eff);
    end
  end

  assign code_f = (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) ?
                  char_code - CASE_OFFSET : char_code;
  assign px = CMP_W'(cell_x);
  assign py = CMP_W'(cell_y);

  // dot index = number of boundaries at or below the offset; the shadow looks
  // one pixel up-left, i.e. boundaries strictly below the offset
  always_comb begin
    item_next.glyph   = font_lookup(code_f);
    item_next.bg      = background_pixel;
    item_next.sh_ok   = (cell_x != '0) && (cell_y != '0);
    item_next.ink_col = '0;
    item_next.sh_col  = '0;
    item_next.ink_row = '0;
    item_next.sh_row  = '0;
    for (int k = 1; k <= GLYPH_COLS; k++) begin
      item_next.ink_col = item_next.ink_col + COL_IDX_W'(px >= thr[k]);
      item_next.sh_col  = item_next.sh_col  + COL_IDX_W'(px >  thr[k]);
    end
    for (int k = 1; k <= GLYPH_ROWS; k++) begin
      item_next.ink_row = item_next.ink_row + ROW_IDX_W'(py >= thr[k]);
      item_next.sh_row  = item_next.sh_row  + ROW_IDX_W'(py >  thr[k]);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

`default_nettype wire

### rtl/core/sgtp_queue.sv
// Short queue between the front and back stages.
`default_nettype none

module sgtp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  sgtp_pkg::sgtp_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output sgtp_pkg::sgtp_item_t rd_item
);
  import sgtp_pkg::*;

  sgtp_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                wr;
  logic                rd;

  assign wr_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_ready && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (wr && !rd) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

`include "scaled_glyph_text_pixel_assert.svh"

  `SGTP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= (QPTR_W + 1)'(QUEUE_DEPTH))
  `SGTP_ASSERT_NEXT(a_count_up, clk, rst, wr && !rd, count == $past(count) + 1'b1)
  `SGTP_ASSERT_NEXT(a_count_down, clk, rst, rd && !wr, count == $past(count) - 1'b1)
  `SGTP_ASSERT_NOW(a_ptr_gap, clk, rst, 1'b1,
                   (wr_ptr - rd_ptr) == QPTR_W'(count))

endmodule

`default_nettype wire

### rtl/core/sgtp_back.sv
// Back stage: dot test, color pick and the result register.
`default_nettype none

module sgtp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sgtp_pkg::sgtp_item_t        in_item,
  input  logic [sgtp_pkg::PIX_W-1:0]  ink_color,
  input  logic [sgtp_pkg::PIX_W-1:0]  shadow_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sgtp_pkg::PIX_W-1:0]  pixel_color,
  output logic [1:0]                  coverage
);
  import sgtp_pkg::*;

  logic              valid;
  logic [PIX_W-1:0]  color;
  cover_t            cov;
  logic [PIX_W-1:0]  color_next;
  cover_t            cov_next;
  logic              ink_dot;
  logic              sh_dot;

  always_comb begin
    ink_dot = 1'b0;
    sh_dot  = 1'b0;
    if (32'(in_item.ink_row) < GLYPH_ROWS && 32'(in_item.ink_col) < GLYPH_COLS) begin
      ink_dot = in_item.glyph[in_item.ink_row]
                             [COL_IDX_W'(GLYPH_COLS - 1) - in_item.ink_col];
    end
    if (in_item.sh_ok && 32'(in_item.sh_row) < GLYPH_ROWS &&
        32'(in_item.sh_col) < GLYPH_COLS) begin
      sh_dot = in_item.glyph[in_item.sh_row]
                            [COL_IDX_W'(GLYPH_COLS - 1) - in_item.sh_col];
    end
  end

  // ink wins over shadow
  always_comb begin
    priority if (ink_dot) begin
      color_next = ink_color;
      cov_next   = COVER_INK;
    end else if (sh_dot) begin
      color_next = shadow_color;
      cov_next   = COVER_SHADOW;
    end else begin
      color_next = in_item.bg;
      cov_next   = COVER_BG;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      color <= color_next;
      cov   <= cov_next;
    end
  end

  assign out_valid   = valid;
  assign pixel_color = color;
  assign coverage    = cov;

endmodule

`default_nettype wire
